// ----- src/assert_macros.svh -----
// Assertion macros used by the matcher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/ftsm_pkg.sv -----
`timescale 1ns / 1ps
package ftsm_pkg;
    localparam int FifoDepthDefault = 16;
    localparam logic [3:0]  BufLimitReset = 4'd10;
    localparam logic [7:0]  LockNeedReset = 8'd4;
    localparam logic [31:0] DelayReset    = 32'd100000;
    localparam logic [47:0] StampMax      = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] RegBufLimit = 3'd0;
    localparam logic [2:0] RegLockNeed = 3'd1;
    localparam logic [2:0] RegDelay    = 3'd2;
    localparam logic [2:0] RegOffset   = 3'd3;
    localparam logic [2:0] RegExpoSrc  = 3'd4;

    localparam logic       CmdFrame   = 1'b0;
    localparam logic       CmdTrigger = 1'b1;

    localparam logic [2:0] EvNone      = 3'd0;
    localparam logic [2:0] EvPublished = 3'd1;
    localparam logic [2:0] EvZero      = 3'd2;
    localparam logic [2:0] EvNonInc    = 3'd3;
    localparam logic [2:0] EvLock      = 3'd4;

    localparam logic [1:0] ExpoPrimary   = 2'd1;
    localparam logic [1:0] ExpoSecondary = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] seq_number;
        logic [15:0] frame_tag;
        logic [47:0] trigger_stamp;
        logic [15:0] exposure_primary;
        logic [15:0] exposure_secondary;
        logic [47:0] arrival_time;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] out_tag;
        logic [31:0] out_number;
        logic [47:0] out_stamp;
        logic [15:0] out_exposure;
        logic        frame_overflow;
        logic        trigger_overflow;
        logic [4:0]  stale_frames;
        logic [4:0]  stale_triggers;
    } out_word_t;

    typedef struct packed {
        logic [3:0]  buffer_limit;
        logic [7:0]  lock_count_needed;
        logic [31:0] delay_limit_us;
        logic [31:0] stamp_offset_us;
        logic [1:0]  exposure_source;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PUSH, ST_SEARCH, ST_MATCH, ST_PURGE_F, ST_PURGE_T,
        ST_LIMIT, ST_DONE
    } seq_state_t;
endpackage

// ----- src/frame_trigger_stamp_matcher_unit.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_stall  | in_word_t
// out     | output    | out_valid / out_stall| out_word_t
// cfg     | input     | APB write, pready=1  | 32-bit registers at 4*i
// Before lock a word passes PUSH and DONE; after lock it also passes SEARCH and LIMIT,
// and on a match MATCH and the purge walks over both queues.
// Reset is asynchronous and active low; queues come up empty.
// The input is stalled while a word is in work or a result waits on out_stall.
module frame_trigger_stamp_matcher_unit
    import ftsm_pkg::*;
#(
    parameter int FIFO_DEPTH = FifoDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data
);
    cfg_t cfg;

    ftsm_cfg_regs u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    ftsm_core #(.FIFO_DEPTH(FIFO_DEPTH)) u_core (
        .clk, .rst_n, .cfg, .in_valid, .in_stall, .in_data,
        .out_valid, .out_stall, .out_data
    );
endmodule

// ----- src/ftsm_cfg_regs.sv -----
`timescale 1ns / 1ps
module ftsm_cfg_regs
    import ftsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);
    cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{BufLimitReset, LockNeedReset, DelayReset, 32'd0, 2'd0};
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                RegBufLimit: cfg_reg.buffer_limit      <= pwdata[3:0];
                RegLockNeed: cfg_reg.lock_count_needed <= pwdata[7:0];
                RegDelay:    cfg_reg.delay_limit_us    <= pwdata;
                RegOffset:   cfg_reg.stamp_offset_us   <= pwdata;
                RegExpoSrc:  cfg_reg.exposure_source   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            RegBufLimit: prdata = {28'd0, cfg_reg.buffer_limit};
            RegLockNeed: prdata = {24'd0, cfg_reg.lock_count_needed};
            RegDelay:    prdata = cfg_reg.delay_limit_us;
            RegOffset:   prdata = cfg_reg.stamp_offset_us;
            RegExpoSrc:  prdata = {30'd0, cfg_reg.exposure_source};
            default:     prdata = 32'd0;
        endcase
    end
endmodule

// ----- src/ftsm_core.sv -----
`timescale 1ns / 1ps
module ftsm_core
    import ftsm_pkg::*;
#(
    parameter int FIFO_DEPTH = FifoDepthDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);
`include "assert_macros.svh"
    localparam int IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(FIFO_DEPTH);

    // Queues are kept compacted; purge is a one-slot-per-cycle walk that
    // copies surviving entries down to a write pointer.
    logic [31:0] fq_num [FIFO_DEPTH];
    logic [15:0] fq_tag [FIFO_DEPTH];
    logic [31:0] tq_num [FIFO_DEPTH];
    logic [47:0] tq_stamp [FIFO_DEPTH];
    logic [15:0] tq_ep [FIFO_DEPTH];
    logic [15:0] tq_es [FIFO_DEPTH];

    seq_state_t state_reg, state_next;
    in_word_t   item_reg;
    logic [CW-1:0] fcnt_reg, tcnt_reg;
    logic [CW-1:0] rd_reg, wr_reg;
    logic [CW-1:0] mf_reg, mt_reg;
    logic          found_reg;
    logic [31:0]   fnum_reg, tnum_reg;
    logic          locked_reg;
    logic [7:0]    ccount_reg;
    logic [32:0]   noff_reg;
    logic [31:0]   ltn_reg;
    logic [47:0]   lta_reg;
    logic [47:0]   lps_reg;
    logic [31:0]   lpn_reg;
    out_word_t     res_reg;
    logic          out_valid_reg;

    // Shared comparator operands: the frame search and the trigger search both use them.
    logic [32:0] cmp_fnum, cmp_tnum_off;
    logic        pair_hit;
    logic [IW-1:0] rd_idx;
    assign rd_idx = rd_reg[IW-1:0];

    always_comb
    begin
        if (item_reg.cmd == CmdFrame)
        begin
            cmp_fnum     = {1'b0, item_reg.seq_number};
            cmp_tnum_off = {1'b0, tq_num[rd_idx]} + noff_reg;
        end
        else
        begin
            cmp_fnum     = {1'b0, fq_num[rd_idx]};
            cmp_tnum_off = {1'b0, item_reg.seq_number} + noff_reg;
        end
        // A wrapped 33-bit sum with the tnum below 2^32 is exact when the
        // offset is in range of a 32-bit difference, as it always is.
        pair_hit = (cmp_fnum == cmp_tnum_off);
    end

    // Stamp: trigger stamp plus signed offset, clamped to 48 bits.
    logic [49:0] stamp_sum;
    logic [47:0] stamp_cl;
    logic [15:0] expo_sel;
    logic [IW-1:0] mt_idx, mf_idx;
    assign mt_idx = mt_reg[IW-1:0];
    assign mf_idx = mf_reg[IW-1:0];
    always_comb
    begin
        stamp_sum = {2'b00, tq_stamp[mt_idx]}
                  + {{18{cfg.stamp_offset_us[31]}}, cfg.stamp_offset_us};
        if (stamp_sum[49])
            stamp_cl = 48'd0;
        else if (stamp_sum[48])
            stamp_cl = StampMax;
        else
            stamp_cl = stamp_sum[47:0];
        unique case (cfg.exposure_source)
            ExpoPrimary:   expo_sel = tq_ep[mt_idx];
            ExpoSecondary: expo_sel = tq_es[mt_idx];
            default:       expo_sel = 16'd0;
        endcase
    end

    logic [32:0] pre_off;
    logic [48:0] pre_gap;
    logic        pre_ok;
    always_comb
    begin
        pre_off = {1'b0, item_reg.seq_number} - {1'b0, ltn_reg};
        pre_gap = {1'b0, item_reg.arrival_time} - {1'b0, lta_reg};
        pre_ok  = (pre_gap[48] || (pre_gap[47:0] < {16'd0, cfg.delay_limit_us}))
                  && (pre_off == noff_reg);
    end

    // The queue of the arriving kind loses its head when it is over the limit.
    logic lim_drop;
    assign lim_drop = (item_reg.cmd == CmdFrame)
                    ? (8'(fcnt_reg) > {4'd0, cfg.buffer_limit})
                    : (8'(tcnt_reg) > {4'd0, cfg.buffer_limit});

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (accept_in) state_next = ST_PUSH;
            ST_PUSH:    state_next = locked_reg ? ST_SEARCH : ST_DONE;
            ST_SEARCH:
            begin
                if (item_reg.cmd == CmdFrame)
                begin
                    if (rd_reg >= tcnt_reg) state_next = ST_LIMIT;
                    else if (pair_hit) state_next = ST_MATCH;
                end
                else
                begin
                    if (rd_reg >= fcnt_reg) state_next = ST_LIMIT;
                    else if (pair_hit) state_next = ST_MATCH;
                end
            end
            ST_MATCH:   state_next = ST_PURGE_F;
            ST_PURGE_F: if (rd_reg >= fcnt_reg) state_next = ST_PURGE_T;
            ST_PURGE_T: if (rd_reg >= tcnt_reg) state_next = ST_LIMIT;
            ST_LIMIT:   state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    logic f_keep, t_keep;
    logic [IW-1:0] wr_idx;
    assign wr_idx = wr_reg[IW-1:0];
    assign f_keep = (rd_reg != mf_reg) && (fq_num[rd_idx] > fnum_reg);
    assign t_keep = (rd_reg != mt_reg) && (tq_num[rd_idx] > tnum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0; tcnt_reg <= '0; rd_reg <= '0; wr_reg <= '0;
            mf_reg <= '0; mt_reg <= '0; found_reg <= 1'b0;
            locked_reg <= 1'b0; ccount_reg <= '0; noff_reg <= '0;
            ltn_reg <= '0; lta_reg <= '0; lps_reg <= '0; lpn_reg <= '0;
            out_valid_reg <= 1'b0; fnum_reg <= '0; tnum_reg <= '0;
            item_reg <= '0; res_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        item_reg <= in_data;
                        res_reg  <= '0;
                        found_reg <= 1'b0;
                    end
                end
                ST_PUSH:
                begin
                    rd_reg <= '0;
                    if (!locked_reg)
                    begin
                        if (item_reg.cmd == CmdTrigger)
                        begin
                            ltn_reg <= item_reg.seq_number;
                            lta_reg <= item_reg.arrival_time;
                        end
                        else
                        begin
                            if (pre_ok)
                            begin
                                if (ccount_reg != 8'hFF) ccount_reg <= ccount_reg + 8'd1;
                                if (((ccount_reg == 8'hFF) ? 9'd255 : {1'b0, ccount_reg} + 9'd1)
                                    >= {1'b0, cfg.lock_count_needed})
                                begin
                                    locked_reg <= 1'b1;
                                    res_reg.event_res <= EvLock;
                                end
                            end
                            else
                                ccount_reg <= '0;
                            noff_reg <= pre_off;
                        end
                    end
                    else if (item_reg.cmd == CmdFrame)
                    begin
                        // A full queue drops its head: push at the tail, then
                        // the limit step may drop one more from the head.
                        if (fcnt_reg >= DepthC)
                        begin
                            for (int k = 0; k < FIFO_DEPTH - 1; k++)
                            begin
                                fq_num[k] <= fq_num[k + 1];
                                fq_tag[k] <= fq_tag[k + 1];
                            end
                            fq_num[FIFO_DEPTH - 1] <= item_reg.seq_number;
                            fq_tag[FIFO_DEPTH - 1] <= item_reg.frame_tag;
                            res_reg.frame_overflow <= 1'b1;
                            mf_reg <= DepthC - 1'b1;
                        end
                        else
                        begin
                            fq_num[fcnt_reg[IW-1:0]] <= item_reg.seq_number;
                            fq_tag[fcnt_reg[IW-1:0]] <= item_reg.frame_tag;
                            fcnt_reg <= fcnt_reg + 1'b1;
                            mf_reg <= fcnt_reg;
                        end
                    end
                    else
                    begin
                        if (tcnt_reg >= DepthC)
                        begin
                            for (int k = 0; k < FIFO_DEPTH - 1; k++)
                            begin
                                tq_num[k]   <= tq_num[k + 1];
                                tq_stamp[k] <= tq_stamp[k + 1];
                                tq_ep[k]    <= tq_ep[k + 1];
                                tq_es[k]    <= tq_es[k + 1];
                            end
                            tq_num[FIFO_DEPTH - 1]   <= item_reg.seq_number;
                            tq_stamp[FIFO_DEPTH - 1] <= item_reg.trigger_stamp;
                            tq_ep[FIFO_DEPTH - 1]    <= item_reg.exposure_primary;
                            tq_es[FIFO_DEPTH - 1]    <= item_reg.exposure_secondary;
                            res_reg.trigger_overflow <= 1'b1;
                            mt_reg <= DepthC - 1'b1;
                        end
                        else
                        begin
                            tq_num[tcnt_reg[IW-1:0]]   <= item_reg.seq_number;
                            tq_stamp[tcnt_reg[IW-1:0]] <= item_reg.trigger_stamp;
                            tq_ep[tcnt_reg[IW-1:0]]    <= item_reg.exposure_primary;
                            tq_es[tcnt_reg[IW-1:0]]    <= item_reg.exposure_secondary;
                            tcnt_reg <= tcnt_reg + 1'b1;
                            mt_reg <= tcnt_reg;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (state_next == ST_MATCH)
                    begin
                        found_reg <= 1'b1;
                        if (item_reg.cmd == CmdFrame) mt_reg <= rd_reg;
                        else mf_reg <= rd_reg;
                    end
                    else
                        rd_reg <= rd_reg + 1'b1;
                end
                ST_MATCH:
                begin
                    fnum_reg <= fq_num[mf_idx];
                    tnum_reg <= tq_num[mt_idx];
                    res_reg.out_tag      <= fq_tag[mf_idx];
                    res_reg.out_number   <= fq_num[mf_idx];
                    res_reg.out_stamp    <= stamp_cl;
                    res_reg.out_exposure <= expo_sel;
                    if (stamp_cl == 48'd0)
                        res_reg.event_res <= EvZero;
                    else if (stamp_cl <= lps_reg)
                        res_reg.event_res <= EvNonInc;
                    else
                    begin
                        res_reg.event_res <= EvPublished;
                        lps_reg <= stamp_cl;
                        lpn_reg <= fq_num[mf_idx];
                    end
                    rd_reg <= '0;
                    wr_reg <= '0;
                end
                ST_PURGE_F:
                begin
                    if (rd_reg >= fcnt_reg)
                    begin
                        fcnt_reg <= wr_reg;
                        rd_reg <= '0;
                        wr_reg <= '0;
                    end
                    else
                    begin
                        if (f_keep)
                        begin
                            fq_num[wr_idx] <= fq_num[rd_idx];
                            fq_tag[wr_idx] <= fq_tag[rd_idx];
                            wr_reg <= wr_reg + 1'b1;
                        end
                        else if (rd_reg != mf_reg && res_reg.stale_frames != 5'd31)
                            res_reg.stale_frames <= res_reg.stale_frames + 5'd1;
                        rd_reg <= rd_reg + 1'b1;
                    end
                end
                ST_PURGE_T:
                begin
                    if (rd_reg >= tcnt_reg)
                    begin
                        tcnt_reg <= wr_reg;
                        rd_reg <= '0;
                    end
                    else
                    begin
                        if (t_keep)
                        begin
                            tq_num[wr_idx]   <= tq_num[rd_idx];
                            tq_stamp[wr_idx] <= tq_stamp[rd_idx];
                            tq_ep[wr_idx]    <= tq_ep[rd_idx];
                            tq_es[wr_idx]    <= tq_es[rd_idx];
                            wr_reg <= wr_reg + 1'b1;
                        end
                        else if (rd_reg != mt_reg && res_reg.stale_triggers != 5'd31)
                            res_reg.stale_triggers <= res_reg.stale_triggers + 5'd1;
                        rd_reg <= rd_reg + 1'b1;
                    end
                end
                ST_LIMIT:
                begin
                    // At most one head entry goes, shifted out in this cycle.
                    if (lim_drop)
                    begin
                        if (item_reg.cmd == CmdFrame)
                        begin
                            for (int k = 0; k < FIFO_DEPTH - 1; k++)
                            begin
                                fq_num[k] <= fq_num[k + 1];
                                fq_tag[k] <= fq_tag[k + 1];
                            end
                            fcnt_reg <= fcnt_reg - 1'b1;
                            res_reg.frame_overflow <= 1'b1;
                        end
                        else
                        begin
                            for (int k = 0; k < FIFO_DEPTH - 1; k++)
                            begin
                                tq_num[k]   <= tq_num[k + 1];
                                tq_stamp[k] <= tq_stamp[k + 1];
                                tq_ep[k]    <= tq_ep[k + 1];
                                tq_es[k]    <= tq_es[k + 1];
                            end
                            tcnt_reg <= tcnt_reg - 1'b1;
                            res_reg.trigger_overflow <= 1'b1;
                        end
                    end
                end
                ST_DONE:
                    out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    `CHK_IMPL(a_count_bound, clk, rst_n, 1'b1, (fcnt_reg <= DepthC) && (tcnt_reg <= DepthC))
    `CHK_NEXT(a_done_valid, clk, rst_n, state_reg == ST_DONE, out_valid_reg)
    `CHK_IMPL(a_busy_stall, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `CHK_NEXT(a_lock_sticky, clk, rst_n, locked_reg, locked_reg)
endmodule
